### sv/aabb_contact_generator_assert.svh
`ifndef AABB_CONTACT_GENERATOR_ASSERT_SVH
`define AABB_CONTACT_GENERATOR_ASSERT_SVH

// cond holds now -> prop holds in the same cycle
`define AABB_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("aabb contact generator check failed");

// cond holds now -> prop holds in the next cycle
`define AABB_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("aabb contact generator check failed");

`endif

### sv/aabb_pkg.sv
package aabb_pkg;

   localparam int CENTER_W = 32;
   localparam int HALF_W   = 31;
   localparam int BOUNCE_W = 17;
   localparam int GRIP_W   = 16;
   localparam int PEN_W    = 32;
   localparam int AXIS_W   = 2;

   // serial datapath: signed words wide enough for every sum, walked one digit a cycle
   localparam int WORD  = 36;
   localparam int DIGIT = 4;
   localparam int NDIG  = WORD / DIGIT;

   localparam int PROD_W     = 2 * GRIP_W;
   localparam int ROOT_W     = GRIP_W;
   localparam int REM_W      = ROOT_W + 2;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int CNT_W      = $clog2(SQRT_STEPS);

   localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

   localparam logic KIND_STORE = 1'b0;
   localparam logic KIND_TEST  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_CALC   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

### sv/aabb_req_if.sv
interface aabb_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 kind;
   logic signed [aabb_pkg::CENTER_W-1:0] center_x;
   logic signed [aabb_pkg::CENTER_W-1:0] center_y;
   logic signed [aabb_pkg::CENTER_W-1:0] center_z;
   logic        [aabb_pkg::HALF_W-1:0]   half_x;
   logic        [aabb_pkg::HALF_W-1:0]   half_y;
   logic        [aabb_pkg::HALF_W-1:0]   half_z;
   logic        [aabb_pkg::BOUNCE_W-1:0] bounce;
   logic        [aabb_pkg::GRIP_W-1:0]   grip;

   modport source (
      output valid, kind, center_x, center_y, center_z, half_x, half_y, half_z,
             bounce, grip,
      input  ready
   );

   modport sink (
      input  valid, kind, center_x, center_y, center_z, half_x, half_y, half_z,
             bounce, grip,
      output ready
   );
endinterface

### sv/aabb_rsp_if.sv
interface aabb_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 hit;
   logic        [aabb_pkg::AXIS_W-1:0]   normal_axis;
   logic                                 normal_negative;
   logic        [aabb_pkg::PEN_W-1:0]    penetration;
   logic signed [aabb_pkg::CENTER_W-1:0] mid_x;
   logic signed [aabb_pkg::CENTER_W-1:0] mid_y;
   logic signed [aabb_pkg::CENTER_W-1:0] mid_z;
   logic        [aabb_pkg::BOUNCE_W-1:0] mixed_bounce;
   logic        [aabb_pkg::GRIP_W-1:0]   mixed_grip;

   modport source (
      output valid, hit, normal_axis, normal_negative, penetration, mid_x, mid_y,
             mid_z, mixed_bounce, mixed_grip,
      input  ready
   );

   modport sink (
      input  valid, hit, normal_axis, normal_negative, penetration, mid_x, mid_y,
             mid_z, mixed_bounce, mixed_grip,
      output ready
   );
endinterface

### sv/aabb_contact_generator.sv
// A store beat (kind 0) is taken while idle and gives no result.
// A test beat (kind 1) runs through calc and finish; finish registers its result and
// returns to idle, but holds while an earlier result waits for ready; the next beat
// is taken once idle. The 16-step friction square root, one root bit a cycle, fills
// calc; the overlap and midpoint sums run meanwhile, 4 bits a cycle over 9 digits.
// Synchronous reset clears stored body A to zero and drops any pending result.
module aabb_contact_generator (
   input  logic         clock,
   input  logic         reset,
   aabb_req_if.sink     req_bus,
   aabb_rsp_if.source   rsp_bus
);

   `include "aabb_contact_generator_assert.svh"

   localparam int WORD  = aabb_pkg::WORD;
   localparam int DIGIT = aabb_pkg::DIGIT;
   localparam int CW    = aabb_pkg::CENTER_W;
   localparam int HW    = aabb_pkg::HALF_W;

   aabb_pkg::state_type state_ff, state_in;
   logic [aabb_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   logic [CW-1:0]                 first_center_ff [3];
   logic [CW-1:0]                 first_center_in [3];
   logic [HW-1:0]                 first_half_ff [3];
   logic [HW-1:0]                 first_half_in [3];
   logic [aabb_pkg::BOUNCE_W-1:0] first_bounce_ff, first_bounce_in;
   logic [aabb_pkg::GRIP_W-1:0]   first_grip_ff, first_grip_in;

   // operand and result shift lines, one lane per axis
   logic [WORD-1:0] ca_sr_ff [3], ca_sr_in [3];
   logic [WORD-1:0] cb_sr_ff [3], cb_sr_in [3];
   logic [WORD-1:0] ha_sr_ff [3], ha_sr_in [3];
   logic [WORD-1:0] hb_sr_ff [3], hb_sr_in [3];
   logic [WORD-1:0] d_sr_ff [3], d_sr_in [3];
   logic [WORD-1:0] m_sr_ff [3], m_sr_in [3];
   logic [WORD-1:0] p_sr_ff [3], p_sr_in [3];
   logic [WORD-1:0] s_sr_ff [3], s_sr_in [3];
   logic            c_hs_ff [3], c_hs_in [3];
   logic            c_d_ff [3], c_d_in [3];
   logic            c_m_ff [3], c_m_in [3];
   logic            c_p_ff [3], c_p_in [3];
   logic            c_s_ff [3], c_s_in [3];
   logic signed [WORD-1:0] ov_ff [3], ov_in [3];

   logic [aabb_pkg::BOUNCE_W-1:0] bnc_ff, bnc_in;
   logic [aabb_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [aabb_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic [aabb_pkg::ROOT_W-1:0]   root_ff, root_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          out_hit_ff, out_hit_in;
   logic [aabb_pkg::AXIS_W-1:0]   out_axis_ff, out_axis_in;
   logic                          out_neg_ff, out_neg_in;
   logic [aabb_pkg::PEN_W-1:0]    out_pen_ff, out_pen_in;
   logic [CW-1:0]                 out_mid_ff [3], out_mid_in [3];
   logic [aabb_pkg::BOUNCE_W-1:0] out_bounce_ff, out_bounce_in;
   logic [aabb_pkg::GRIP_W-1:0]   out_grip_ff, out_grip_in;

   logic [CW-1:0] in_center [3];
   logic [HW-1:0] in_half [3];
   logic          req_take;

   logic [DIGIT:0] hs_sum [3];
   logic [DIGIT:0] d_sum [3];
   logic [DIGIT:0] m_sum [3];
   logic [DIGIT:0] p_sum [3];
   logic [DIGIT:0] s_sum [3];

   logic [aabb_pkg::REM_W+1:0]  rem_sh;
   logic [aabb_pkg::REM_W+1:0]  trial;
   logic [aabb_pkg::BOUNCE_W:0] bsum;

   logic                        ov_pos [3];
   logic                        all_hit;
   logic [aabb_pkg::AXIS_W-1:0] sel_axis;
   logic                        sel_neg;
   logic [aabb_pkg::PEN_W-1:0]  sel_pen;

   assign req_bus.ready = (state_ff == aabb_pkg::ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.hit             = out_hit_ff;
   assign rsp_bus.normal_axis     = out_axis_ff;
   assign rsp_bus.normal_negative = out_neg_ff;
   assign rsp_bus.penetration     = out_pen_ff;
   assign rsp_bus.mid_x           = out_mid_ff[0];
   assign rsp_bus.mid_y           = out_mid_ff[1];
   assign rsp_bus.mid_z           = out_mid_ff[2];
   assign rsp_bus.mixed_bounce    = out_bounce_ff;
   assign rsp_bus.mixed_grip      = out_grip_ff;

   always_comb begin
      in_center[0] = req_bus.center_x;
      in_center[1] = req_bus.center_y;
      in_center[2] = req_bus.center_z;
      in_half[0]   = req_bus.half_x;
      in_half[1]   = req_bus.half_y;
      in_half[2]   = req_bus.half_z;
   end

   // one digit of every serial adder, all lanes side by side
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         hs_sum[i] = {1'b0, ha_sr_ff[i][DIGIT-1:0]} + {1'b0, hb_sr_ff[i][DIGIT-1:0]}
                   + {{DIGIT{1'b0}}, c_hs_ff[i]};
         d_sum[i]  = {1'b0, cb_sr_ff[i][DIGIT-1:0]} + {1'b0, ~ca_sr_ff[i][DIGIT-1:0]}
                   + {{DIGIT{1'b0}}, c_d_ff[i]};
         m_sum[i]  = {1'b0, hs_sum[i][DIGIT-1:0]} + {1'b0, ~d_sum[i][DIGIT-1:0]}
                   + {{DIGIT{1'b0}}, c_m_ff[i]};
         p_sum[i]  = {1'b0, hs_sum[i][DIGIT-1:0]} + {1'b0, d_sum[i][DIGIT-1:0]}
                   + {{DIGIT{1'b0}}, c_p_ff[i]};
         s_sum[i]  = {1'b0, ca_sr_ff[i][DIGIT-1:0]} + {1'b0, cb_sr_ff[i][DIGIT-1:0]}
                   + {{DIGIT{1'b0}}, c_s_ff[i]};
      end
   end

   // one root bit per step: bring down two product bits, try root*4+1
   always_comb begin
      rem_sh = {rem_ff, prod_ff[aabb_pkg::PROD_W-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};
      bsum   = {1'b0, first_bounce_ff} + {1'b0, req_bus.bounce};
   end

   // least-overlap axis: x only if strictly least, then y over z, ties to z
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ov_pos[i] = !ov_ff[i][WORD-1] && (ov_ff[i] != '0);
      end
      all_hit = ov_pos[0] && ov_pos[1] && ov_pos[2];
      if (ov_ff[0] < ov_ff[1] && ov_ff[0] < ov_ff[2]) begin
         sel_axis = aabb_pkg::AXIS_X;
      end else if (ov_ff[1] < ov_ff[2]) begin
         sel_axis = aabb_pkg::AXIS_Y;
      end else begin
         sel_axis = aabb_pkg::AXIS_Z;
      end
      case (sel_axis)
         aabb_pkg::AXIS_X: begin
            sel_neg = d_sr_ff[0][WORD-1];
            sel_pen = ov_ff[0][aabb_pkg::PEN_W-1:0];
         end
         aabb_pkg::AXIS_Y: begin
            sel_neg = d_sr_ff[1][WORD-1];
            sel_pen = ov_ff[1][aabb_pkg::PEN_W-1:0];
         end
         default: begin
            sel_neg = d_sr_ff[2][WORD-1];
            sel_pen = ov_ff[2][aabb_pkg::PEN_W-1:0];
         end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      first_bounce_in = first_bounce_ff;
      first_grip_in   = first_grip_ff;
      bnc_in          = bnc_ff;
      prod_in         = prod_ff;
      rem_in          = rem_ff;
      root_in         = root_ff;
      rsp_valid_in    = rsp_valid_ff;
      out_hit_in      = out_hit_ff;
      out_axis_in     = out_axis_ff;
      out_neg_in      = out_neg_ff;
      out_pen_in      = out_pen_ff;
      out_bounce_in   = out_bounce_ff;
      out_grip_in     = out_grip_ff;
      for (int i = 0; i < 3; i++) begin
         first_center_in[i] = first_center_ff[i];
         first_half_in[i]   = first_half_ff[i];
         ca_sr_in[i] = ca_sr_ff[i];
         cb_sr_in[i] = cb_sr_ff[i];
         ha_sr_in[i] = ha_sr_ff[i];
         hb_sr_in[i] = hb_sr_ff[i];
         d_sr_in[i]  = d_sr_ff[i];
         m_sr_in[i]  = m_sr_ff[i];
         p_sr_in[i]  = p_sr_ff[i];
         s_sr_in[i]  = s_sr_ff[i];
         c_hs_in[i]  = c_hs_ff[i];
         c_d_in[i]   = c_d_ff[i];
         c_m_in[i]   = c_m_ff[i];
         c_p_in[i]   = c_p_ff[i];
         c_s_in[i]   = c_s_ff[i];
         ov_in[i]    = ov_ff[i];
         out_mid_in[i] = out_mid_ff[i];
      end

      // drop the delivered beat; a new load below overrides
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         aabb_pkg::ST_IDLE: begin
            if (req_take && req_bus.kind == aabb_pkg::KIND_STORE) begin
               for (int i = 0; i < 3; i++) begin
                  first_center_in[i] = in_center[i];
                  first_half_in[i]   = in_half[i];
               end
               first_bounce_in = req_bus.bounce;
               first_grip_in   = req_bus.grip;
            end else if (req_take) begin
               for (int i = 0; i < 3; i++) begin
                  ca_sr_in[i] = {{(WORD-CW){first_center_ff[i][CW-1]}}, first_center_ff[i]};
                  cb_sr_in[i] = {{(WORD-CW){in_center[i][CW-1]}}, in_center[i]};
                  ha_sr_in[i] = {{(WORD-HW){1'b0}}, first_half_ff[i]};
                  hb_sr_in[i] = {{(WORD-HW){1'b0}}, in_half[i]};
                  c_hs_in[i]  = 1'b0;
                  c_d_in[i]   = 1'b1;
                  c_m_in[i]   = 1'b1;
                  c_p_in[i]   = 1'b0;
                  c_s_in[i]   = 1'b0;
               end
               bnc_in   = bsum[aabb_pkg::BOUNCE_W:1];
               prod_in  = aabb_pkg::PROD_W'(first_grip_ff) * aabb_pkg::PROD_W'(req_bus.grip);
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = aabb_pkg::ST_CALC;
            end
         end
         aabb_pkg::ST_CALC: begin
            if (rem_sh >= trial) begin
               rem_in  = aabb_pkg::REM_W'(rem_sh - trial);
               root_in = {root_ff[aabb_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh[aabb_pkg::REM_W-1:0];
               root_in = {root_ff[aabb_pkg::ROOT_W-2:0], 1'b0};
            end
            prod_in = {prod_ff[aabb_pkg::PROD_W-3:0], 2'b00};

            if (cnt_ff < aabb_pkg::CNT_W'(aabb_pkg::NDIG)) begin
               for (int i = 0; i < 3; i++) begin
                  ca_sr_in[i] = {{DIGIT{1'b0}}, ca_sr_ff[i][WORD-1:DIGIT]};
                  cb_sr_in[i] = {{DIGIT{1'b0}}, cb_sr_ff[i][WORD-1:DIGIT]};
                  ha_sr_in[i] = {{DIGIT{1'b0}}, ha_sr_ff[i][WORD-1:DIGIT]};
                  hb_sr_in[i] = {{DIGIT{1'b0}}, hb_sr_ff[i][WORD-1:DIGIT]};
                  d_sr_in[i]  = {d_sum[i][DIGIT-1:0], d_sr_ff[i][WORD-1:DIGIT]};
                  m_sr_in[i]  = {m_sum[i][DIGIT-1:0], m_sr_ff[i][WORD-1:DIGIT]};
                  p_sr_in[i]  = {p_sum[i][DIGIT-1:0], p_sr_ff[i][WORD-1:DIGIT]};
                  s_sr_in[i]  = {s_sum[i][DIGIT-1:0], s_sr_ff[i][WORD-1:DIGIT]};
                  c_hs_in[i]  = hs_sum[i][DIGIT];
                  c_d_in[i]   = d_sum[i][DIGIT];
                  c_m_in[i]   = m_sum[i][DIGIT];
                  c_p_in[i]   = p_sum[i][DIGIT];
                  c_s_in[i]   = s_sum[i][DIGIT];
               end
            end else if (cnt_ff == aabb_pkg::CNT_W'(aabb_pkg::NDIG)) begin
               // overlap = halves - |d|: pick halves+d when d is negative
               for (int i = 0; i < 3; i++) begin
                  ov_in[i] = d_sr_ff[i][WORD-1] ? p_sr_ff[i] : m_sr_ff[i];
               end
            end

            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == aabb_pkg::CNT_W'(aabb_pkg::SQRT_STEPS - 1)) begin
               state_in = aabb_pkg::ST_FINISH;
            end
         end
         aabb_pkg::ST_FINISH: begin
            // hold until the output slot is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               if (all_hit) begin
                  out_hit_in    = 1'b1;
                  out_axis_in   = sel_axis;
                  out_neg_in    = sel_neg;
                  out_pen_in    = sel_pen;
                  out_bounce_in = bnc_ff;
                  out_grip_in   = root_ff;
                  for (int i = 0; i < 3; i++) begin
                     out_mid_in[i] = s_sr_ff[i][CW:1];
                  end
               end else begin
                  out_hit_in    = 1'b0;
                  out_axis_in   = aabb_pkg::AXIS_X;
                  out_neg_in    = 1'b0;
                  out_pen_in    = '0;
                  out_bounce_in = '0;
                  out_grip_in   = '0;
                  for (int i = 0; i < 3; i++) begin
                     out_mid_in[i] = '0;
                  end
               end
               state_in = aabb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aabb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= aabb_pkg::ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         first_bounce_ff <= '0;
         first_grip_ff   <= '0;
         for (int i = 0; i < 3; i++) begin
            first_center_ff[i] <= '0;
            first_half_ff[i]   <= '0;
         end
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         first_bounce_ff <= first_bounce_in;
         first_grip_ff   <= first_grip_in;
         for (int i = 0; i < 3; i++) begin
            first_center_ff[i] <= first_center_in[i];
            first_half_ff[i]   <= first_half_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      bnc_ff        <= bnc_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      out_hit_ff    <= out_hit_in;
      out_axis_ff   <= out_axis_in;
      out_neg_ff    <= out_neg_in;
      out_pen_ff    <= out_pen_in;
      out_bounce_ff <= out_bounce_in;
      out_grip_ff   <= out_grip_in;
      for (int i = 0; i < 3; i++) begin
         ca_sr_ff[i]   <= ca_sr_in[i];
         cb_sr_ff[i]   <= cb_sr_in[i];
         ha_sr_ff[i]   <= ha_sr_in[i];
         hb_sr_ff[i]   <= hb_sr_in[i];
         d_sr_ff[i]    <= d_sr_in[i];
         m_sr_ff[i]    <= m_sr_in[i];
         p_sr_ff[i]    <= p_sr_in[i];
         s_sr_ff[i]    <= s_sr_in[i];
         c_hs_ff[i]    <= c_hs_in[i];
         c_d_ff[i]     <= c_d_in[i];
         c_m_ff[i]     <= c_m_in[i];
         c_p_ff[i]     <= c_p_in[i];
         c_s_ff[i]     <= c_s_in[i];
         ov_ff[i]      <= ov_in[i];
         out_mid_ff[i] <= out_mid_in[i];
      end
   end

   `AABB_ASSERT_NEXT(a_test_starts, clock, reset,
      req_take && req_bus.kind == aabb_pkg::KIND_TEST,
      state_ff == aabb_pkg::ST_CALC && cnt_ff == '0)
   `AABB_ASSERT_NEXT(a_finish_lands, clock, reset,
      state_ff == aabb_pkg::ST_FINISH && !rsp_valid_ff,
      rsp_valid_ff && state_ff == aabb_pkg::ST_IDLE)
   `AABB_ASSERT_NOW(a_miss_zeroed, clock, reset,
      rsp_valid_ff && !out_hit_ff,
      out_pen_ff == '0 && out_grip_ff == '0 && out_bounce_ff == '0)
   `AABB_ASSERT_NOW(a_hit_depth, clock, reset,
      rsp_valid_ff && out_hit_ff,
      out_pen_ff != '0 && out_axis_ff <= aabb_pkg::AXIS_Z)

endmodule

### verif/aabb_contact_generator_tb.sv
module aabb_contact_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CENTER_W = aabb_pkg::CENTER_W;
   localparam int HALF_W   = aabb_pkg::HALF_W;
   localparam int BOUNCE_W = aabb_pkg::BOUNCE_W;
   localparam int GRIP_W   = aabb_pkg::GRIP_W;
   localparam int PEN_W    = aabb_pkg::PEN_W;
   localparam int AXIS_W   = aabb_pkg::AXIS_W;
   localparam int PROD_W   = aabb_pkg::PROD_W;

   localparam int CENTER_MIN   = 32'sh8000_0000;
   localparam int CENTER_MAX   = 32'sh7FFF_FFFF;
   localparam int HALF_MAX     = 32'sh7FFF_FFFF;
   localparam int BOUNCE_ONE   = 65536;
   localparam int BOUNCE_TOP   = 131071;
   localparam int GRIP_MAX     = 65535;
   localparam int ONE          = 65536;     // 1.0 in Q16.16
   localparam int GAP_MAX      = 17;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 2000;

   typedef logic signed [aabb_pkg::WORD-1:0] wide_type;

   typedef struct packed {
      logic                           kind;
      logic [2:0][CENTER_W-1:0]       center;
      logic [2:0][HALF_W-1:0]         half;
      logic [BOUNCE_W-1:0]            bounce;
      logic [GRIP_W-1:0]              grip;
   } body_type;

   typedef struct packed {
      logic                           hit;
      logic [AXIS_W-1:0]              axis;
      logic                           negative;
      logic [PEN_W-1:0]               penetration;
      logic [2:0][CENTER_W-1:0]       mid;
      logic [BOUNCE_W-1:0]            mixed_bounce;
      logic [GRIP_W-1:0]              mixed_grip;
   } contact_type;

   class contact_scoreboard;
      logic [2:0][CENTER_W-1:0] a_center;
      logic [2:0][HALF_W-1:0]   a_half;
      logic [BOUNCE_W-1:0]      a_bounce;
      logic [GRIP_W-1:0]        a_grip;
      contact_type              contacts_due[$];
      int                       errors;

      function new();
         a_center = '0;
         a_half   = '0;
         a_bounce = '0;
         a_grip   = '0;
         errors   = 0;
      endfunction

      function int pending();
         return contacts_due.size();
      endfunction

      // floor square root, one root bit per step from the top
      function logic [GRIP_W-1:0] grip_root(logic [PROD_W-1:0] product);
         logic [GRIP_W-1:0] root;
         logic [GRIP_W-1:0] trial;
         logic [PROD_W-1:0] square;
         root = '0;
         for (int b = GRIP_W-1; b >= 0; b--) begin
            trial  = root | (GRIP_W'(1) << b);
            square = PROD_W'(trial) * PROD_W'(trial);
            if (square <= product) root = trial;
         end
         return root;
      endfunction

      function contact_type predict_contact(body_type b);
         contact_type       c;
         wide_type          delta [3];
         wide_type          overlap [3];
         wide_type          ca, cb, reach, distance, sum;
         int                pick;
         logic [BOUNCE_W:0] bounce_sum;
         logic [PROD_W-1:0] product;
         c = '0;
         for (int i = 0; i < 3; i++) begin
            ca = wide_type'($signed(a_center[i]));
            cb = wide_type'($signed(b.center[i]));
            delta[i] = cb - ca;
            distance = (delta[i] < 0) ? -delta[i] : delta[i];
            reach = wide_type'(a_half[i]) + wide_type'(b.half[i]);
            overlap[i] = reach - distance;
         end
         if (overlap[0] <= 0 || overlap[1] <= 0 || overlap[2] <= 0) return c;

         // x only on a strict win, y beats z only strictly, else z
         if (overlap[0] < overlap[1] && overlap[0] < overlap[2]) begin
            pick = 0;
            c.axis = aabb_pkg::AXIS_X;
         end else if (overlap[1] < overlap[2]) begin
            pick = 1;
            c.axis = aabb_pkg::AXIS_Y;
         end else begin
            pick = 2;
            c.axis = aabb_pkg::AXIS_Z;
         end
         c.hit         = 1'b1;
         c.negative    = delta[pick] < 0;
         c.penetration = overlap[pick][PEN_W-1:0];
         for (int i = 0; i < 3; i++) begin
            ca = wide_type'($signed(a_center[i]));
            cb = wide_type'($signed(b.center[i]));
            sum = (ca + cb) >>> 1;
            c.mid[i] = sum[CENTER_W-1:0];
         end
         bounce_sum = {1'b0, a_bounce} + {1'b0, b.bounce};
         c.mixed_bounce = bounce_sum[BOUNCE_W:1];
         product = PROD_W'(a_grip) * PROD_W'(b.grip);
         c.mixed_grip = grip_root(product);
         return c;
      endfunction

      function void note_body(body_type b);
         if (b.kind == aabb_pkg::KIND_STORE) begin
            a_center = b.center;
            a_half   = b.half;
            a_bounce = b.bounce;
            a_grip   = b.grip;
         end else begin
            contacts_due.push_back(predict_contact(b));
         end
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH at %0t ns: %s", $time, msg);
      endtask

      task check_contact(contact_type got);
         contact_type want;
         if (contacts_due.size() == 0) begin
            report("result beat with no test outstanding");
            return;
         end
         want = contacts_due.pop_front();
         if (got.hit !== want.hit)
            report($sformatf("hit got %h, expected %h", got.hit, want.hit));
         if (got.axis !== want.axis)
            report($sformatf("normal_axis got %h, expected %h", got.axis, want.axis));
         if (got.negative !== want.negative)
            report($sformatf("normal_negative got %h, expected %h",
                             got.negative, want.negative));
         if (got.penetration !== want.penetration)
            report($sformatf("penetration got %h, expected %h",
                             got.penetration, want.penetration));
         if (got.mid[0] !== want.mid[0])
            report($sformatf("mid_x got %h, expected %h", got.mid[0], want.mid[0]));
         if (got.mid[1] !== want.mid[1])
            report($sformatf("mid_y got %h, expected %h", got.mid[1], want.mid[1]));
         if (got.mid[2] !== want.mid[2])
            report($sformatf("mid_z got %h, expected %h", got.mid[2], want.mid[2]));
         if (got.mixed_bounce !== want.mixed_bounce)
            report($sformatf("mixed_bounce got %h, expected %h",
                             got.mixed_bounce, want.mixed_bounce));
         if (got.mixed_grip !== want.mixed_grip)
            report($sformatf("mixed_grip got %h, expected %h",
                             got.mixed_grip, want.mixed_grip));
      endtask
   endclass

   logic clock;
   logic reset;
   logic send_quiet;
   logic take_quiet;
   body_type stored_a;
   contact_scoreboard board;

   aabb_req_if req_bus ();
   aabb_rsp_if rsp_bus ();

   aabb_contact_generator DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : watchdog
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // observe both channels; results first, they belong to older tests
   always @(posedge clock) begin : watch
      body_type    seen;
      contact_type got;
      if (!reset) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.hit          = rsp_bus.hit;
            got.axis         = rsp_bus.normal_axis;
            got.negative     = rsp_bus.normal_negative;
            got.penetration  = rsp_bus.penetration;
            got.mid[0]       = rsp_bus.mid_x;
            got.mid[1]       = rsp_bus.mid_y;
            got.mid[2]       = rsp_bus.mid_z;
            got.mixed_bounce = rsp_bus.mixed_bounce;
            got.mixed_grip   = rsp_bus.mixed_grip;
            board.check_contact(got);
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            seen.kind      = req_bus.kind;
            seen.center[0] = req_bus.center_x;
            seen.center[1] = req_bus.center_y;
            seen.center[2] = req_bus.center_z;
            seen.half[0]   = req_bus.half_x;
            seen.half[1]   = req_bus.half_y;
            seen.half[2]   = req_bus.half_z;
            seen.bounce    = req_bus.bounce;
            seen.grip      = req_bus.grip;
            board.note_body(seen);
         end
      end
   end

   task automatic put_payload(body_type b);
      req_bus.kind     <= b.kind;
      req_bus.center_x <= b.center[0];
      req_bus.center_y <= b.center[1];
      req_bus.center_z <= b.center[2];
      req_bus.half_x   <= b.half[0];
      req_bus.half_y   <= b.half[1];
      req_bus.half_z   <= b.half[2];
      req_bus.bounce   <= b.bounce;
      req_bus.grip     <= b.grip;
   endtask

   // valid drops only ahead of a real gap, so a back-to-back beat never toggles it
   task automatic send_body(body_type b);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      put_payload(b);
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (b.kind == aabb_pkg::KIND_STORE) stored_a = b;
   endtask

   function automatic body_type make_body(logic kind, int cx, int cy, int cz,
                                          int hx, int hy, int hz, int bn, int gr);
      body_type b;
      b.kind      = kind;
      b.center[0] = CENTER_W'(cx);
      b.center[1] = CENTER_W'(cy);
      b.center[2] = CENTER_W'(cz);
      b.half[0]   = HALF_W'(hx);
      b.half[1]   = HALF_W'(hy);
      b.half[2]   = HALF_W'(hz);
      b.bounce    = BOUNCE_W'(bn);
      b.grip      = GRIP_W'(gr);
      return b;
   endfunction

   function automatic logic [CENTER_W-1:0] pick_center();
      case ($urandom_range(0, 7))
         0:       return CENTER_W'(CENTER_MIN);
         1:       return CENTER_W'(CENTER_MAX);
         2, 3:    return $urandom;
         default: return $urandom_range(0, 1 << 23) - (1 << 22);
      endcase
   endfunction

   function automatic logic [HALF_W-1:0] pick_half();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return HALF_W'(HALF_MAX);
         2:       return HALF_W'($urandom);
         default: return HALF_W'($urandom_range(0, 1 << 21));
      endcase
   endfunction

   function automatic logic [BOUNCE_W-1:0] pick_bounce();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return BOUNCE_W'(BOUNCE_ONE);
         2:       return BOUNCE_W'($urandom);
         default: return BOUNCE_W'($urandom_range(0, BOUNCE_ONE));
      endcase
   endfunction

   function automatic logic [GRIP_W-1:0] pick_grip();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return GRIP_W'(GRIP_MAX);
         default: return GRIP_W'($urandom);
      endcase
   endfunction

   function automatic body_type random_body(logic kind);
      body_type b;
      b.kind = kind;
      for (int i = 0; i < 3; i++) begin
         b.center[i] = pick_center();
         b.half[i]   = pick_half();
      end
      b.bounce = pick_bounce();
      b.grip   = pick_grip();
      return b;
   endfunction

   // test body placed around the stored A so that axes often land on or near the overlap edge
   function automatic body_type aim_test();
      body_type    b;
      longint      reach;
      longint      shift;
      int unsigned span;
      logic        tied;
      b.kind   = aabb_pkg::KIND_TEST;
      b.bounce = pick_bounce();
      b.grip   = pick_grip();
      tied     = ($urandom_range(0, 7) == 0);
      span     = $urandom_range(0, 1 << 16);
      for (int i = 0; i < 3; i++) begin
         if (tied) begin
            // equal reach and equal distance on all axes
            b.half[i] = HALF_W'(HALF_MAX) - stored_a.half[i];
            shift = longint'(span);
         end else begin
            b.half[i] = pick_half();
            reach = longint'(stored_a.half[i]) + longint'(b.half[i]);
            case ($urandom_range(0, 9))
               0:       shift = reach;
               1:       shift = reach - 1;
               2:       shift = longint'($urandom);
               default: begin
                  span  = (reach > (1 << 30)) ? (1 << 30) : int'(reach) + ONE;
                  shift = longint'($urandom_range(0, span));
               end
            endcase
         end
         if ($urandom_range(0, 1)) shift = -shift;
         b.center[i] = stored_a.center[i] + CENTER_W'(shift);
      end
      return b;
   endfunction

   initial begin : stimulus
      int choice;
      board      = new();
      stored_a   = '0;
      send_quiet = 1'b0;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      put_payload('0);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // test against the cleared body A
      send_body(make_body(aabb_pkg::KIND_TEST, 0, 0, 0, ONE, ONE, ONE, 100, 'h100));
      // extremes of every field
      send_body(make_body(aabb_pkg::KIND_STORE, 0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX,
                          BOUNCE_ONE, GRIP_MAX));
      send_body(make_body(aabb_pkg::KIND_TEST, CENTER_MIN, CENTER_MIN, CENTER_MIN,
                          HALF_MAX, HALF_MAX, HALF_MAX, BOUNCE_ONE, GRIP_MAX));
      send_body(make_body(aabb_pkg::KIND_TEST, 0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX,
                          0, 0));
      send_body(make_body(aabb_pkg::KIND_STORE, CENTER_MAX, CENTER_MAX, CENTER_MAX,
                          HALF_MAX, HALF_MAX, HALF_MAX, 0, 0));
      send_body(make_body(aabb_pkg::KIND_TEST, CENTER_MIN, CENTER_MIN, CENTER_MIN,
                          HALF_MAX, HALF_MAX, HALF_MAX, BOUNCE_ONE, GRIP_MAX));
      send_body(make_body(aabb_pkg::KIND_TEST, CENTER_MAX, CENTER_MAX, CENTER_MAX,
                          0, 0, 0, BOUNCE_TOP, GRIP_MAX));
      // axis selection, signs and ties
      send_body(make_body(aabb_pkg::KIND_STORE, 0, 0, 0, 10*ONE, 20*ONE, 30*ONE, 1, 3));
      send_body(make_body(aabb_pkg::KIND_TEST, -ONE, 0, 0, ONE, ONE, ONE, 0, 5));
      send_body(make_body(aabb_pkg::KIND_TEST, 0, ONE, 0, 15*ONE, ONE, ONE, 2, 7));
      send_body(make_body(aabb_pkg::KIND_TEST, 0, 0, -ONE, 20*ONE, 15*ONE, 0, 3, 9));
      send_body(make_body(aabb_pkg::KIND_TEST, 0, 0, 0, 10*ONE, 0, 5*ONE, 4, 11));
      send_body(make_body(aabb_pkg::KIND_TEST, 0, 0, 0, 20*ONE, 20*ONE, 0, 5, 13));
      send_body(make_body(aabb_pkg::KIND_TEST, 0, 0, 0, 30*ONE, 10*ONE, 0, 6, 15));
      // boxes that just touch, and that overlap by one step
      send_body(make_body(aabb_pkg::KIND_TEST, 11*ONE, 0, 0, ONE, ONE, ONE, 7, 17));
      send_body(make_body(aabb_pkg::KIND_TEST, 0, -21*ONE, 0, ONE, ONE, ONE, 8, 19));
      send_body(make_body(aabb_pkg::KIND_TEST, 0, 0, 31*ONE, ONE, ONE, ONE, 9, 21));
      send_body(make_body(aabb_pkg::KIND_TEST, 11*ONE - 1, 0, 0, ONE, ONE, ONE, 10, 23));
      // odd and negative center sums round down
      send_body(make_body(aabb_pkg::KIND_STORE, -5*ONE, 7*ONE + 1, -1, ONE, ONE, ONE,
                          BOUNCE_ONE - 1, 'h200));
      send_body(make_body(aabb_pkg::KIND_TEST, -5*ONE + 3, 7*ONE, 0, ONE, ONE, ONE,
                          BOUNCE_ONE, 'h800));
      send_body(make_body(aabb_pkg::KIND_TEST, -5*ONE - 2, 7*ONE - 4, -2, ONE, ONE, ONE,
                          BOUNCE_TOP, GRIP_MAX));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) send_quiet = ($urandom_range(0, 3) == 0);
         choice = $urandom_range(0, 19);
         if (choice < 5)       send_body(random_body(aabb_pkg::KIND_STORE));
         else if (choice == 5) send_body(random_body(aabb_pkg::KIND_TEST));
         else                  send_body(aim_test());
      end
      req_bus.valid <= 1'b0;

      // let the monitor note the last beat before counting what is outstanding
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // result side: stall a random number of cycles before each beat
   initial begin : take_side
      int gap;
      int beats;
      rsp_bus.ready <= 1'b0;
      take_quiet = 1'b0;
      beats = 0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (beats % 50 == 0) take_quiet = ($urandom_range(0, 3) == 0);
         gap = take_quiet ? 0 : $urandom_range(0, GAP_MAX);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         beats++;
      end
   end

endmodule

### filelist.f
+incdir+sv
sv/aabb_pkg.sv
sv/aabb_req_if.sv
sv/aabb_rsp_if.sv
sv/aabb_contact_generator.sv
verif/aabb_contact_generator_tb.sv
